// ----- src/fppd_pkg.sv -----
// Package for the flow pulse pour detector.
// Holds the transaction types, command and status structs, codes and reset values.
// No dependencies.
`default_nettype none

package fppd_pkg;

    localparam int CHANNELS_DEF = 4;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_ACTIVE    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic [2:0]  ACTIVE_RST    = 3'd4;
    localparam logic [30:0] TIMEOUT_RST   = 31'd1000;
    localparam logic [15:0] THRESHOLD_RST = 16'd0;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_STOP   = 2'd2;

    localparam logic [1:0] EVT_STATUS     = 2'd0;
    localparam logic [1:0] EVT_POUR_START = 2'd1;
    localparam logic [1:0] EVT_POUR_END   = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [3:0]  pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [1:0]  channel;
        logic [15:0] pulse_count;
        logic [31:0] duration_ms;
        logic        have_data;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic do_start;
        logic do_stop;
        logic edge_step;
        logic idle_step;
        logic emit_status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       running;
        logic       n_zero;
        logic       last_ch;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- src/fppd_datapath.sv -----
// Datapath of the flow pulse pour detector: configuration registers, channel state,
// per-channel edge and idle checks, and the result register.
// Depends on fppd_pkg.
`default_nettype none

module fppd_datapath #(
    parameter int CHANNELS = fppd_pkg::CHANNELS_DEF,
    parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fppd_pkg::t_in_item            i_in_data,
    output      fppd_pkg::t_out_item           o_out_data,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fppd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fppd_pkg::PDATA_W-1:0]  pwdata,
    output      logic [fppd_pkg::PDATA_W-1:0]  prdata,
    input  wire fppd_pkg::t_cmd                i_cmd,
    input  wire logic [CW-1:0]                 i_ch,
    output      fppd_pkg::t_stat               o_stat
);
    import fppd_pkg::*;

    localparam int NW = $clog2(CHANNELS + 1);

    logic [2:0]  r_active;
    logic [30:0] r_timeout;
    logic [15:0] r_thr;

    logic [1:0]  r_req;
    logic [31:0] r_now;
    logic [3:0]  r_levels;
    logic        r_have;
    logic        r_running;

    logic        r_prev  [CHANNELS];
    logic [15:0] r_total [CHANNELS];
    logic [31:0] r_last  [CHANNELS];
    logic [31:0] r_first [CHANNELS];

    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        n_load;

    logic [NW-1:0] n_used;
    logic [CW+1:0] ch_ext;
    logic          lvl;
    logic          cur_prev;
    logic [15:0]   cur_total;
    logic [31:0]   cur_last;
    logic [31:0]   cur_first;
    logic [31:0]   diff;
    logic          changed;
    logic          gap_ok;
    logic          start_ev;
    logic          timed_out;
    logic          last_pos;
    logic          end_ev;
    logic          out_free;
    logic          cfg_wr;

    assign n_used = (int'(r_active) > CHANNELS) ? NW'(CHANNELS) : NW'(r_active);

    assign ch_ext    = {2'b00, i_ch};
    assign lvl       = (ch_ext < (CW+2)'(4)) ? r_levels[ch_ext[1:0]] : 1'b0;
    assign cur_prev  = r_prev[i_ch];
    assign cur_total = r_total[i_ch];
    assign cur_last  = r_last[i_ch];
    assign cur_first = r_first[i_ch];
    assign diff      = r_now - cur_last;
    assign changed   = (lvl != cur_prev);
    assign gap_ok    = ($signed(diff) > 32'sd1);
    assign start_ev  = changed && lvl && gap_ok && (cur_total == r_thr);
    assign timed_out = ($signed({diff[31], diff}) > $signed({2'b00, r_timeout}));
    assign last_pos  = !cur_last[31] && (cur_last != 32'd0);
    assign end_ev    = timed_out && last_pos && (cur_total != 16'd0) && (cur_total > r_thr);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign cfg_wr    = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_ACTIVE:    prdata = {29'd0, r_active};
            REG_TIMEOUT:   prdata = {1'b0, r_timeout};
            REG_THRESHOLD: prdata = {16'd0, r_thr};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        n_load = 1'b0;
        n_out  = '0;
        if (i_cmd.edge_step && start_ev) begin
            n_load           = 1'b1;
            n_out.event_kind = EVT_POUR_START;
            n_out.channel    = ch_ext[1:0];
        end else if (i_cmd.idle_step && end_ev) begin
            n_load            = 1'b1;
            n_out.event_kind  = EVT_POUR_END;
            n_out.channel     = ch_ext[1:0];
            n_out.pulse_count = cur_total;
            n_out.duration_ms = cur_last - cur_first;
        end else if (i_cmd.emit_status) begin
            n_load            = 1'b1;
            n_out.event_kind  = EVT_STATUS;
            n_out.have_data   = r_have;
            n_out.last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_req    <= i_in_data.req_type;
            r_now    <= i_in_data.now_ms;
            r_levels <= i_in_data.pin_levels;
        end
        if (n_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= ACTIVE_RST;
            r_timeout   <= TIMEOUT_RST;
            r_thr       <= THRESHOLD_RST;
            r_running   <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_prev[i]  <= 1'b0;
                r_total[i] <= '0;
                r_last[i]  <= '0;
                r_first[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_ACTIVE:    r_active  <= pwdata[2:0];
                    REG_TIMEOUT:   r_timeout <= pwdata[30:0];
                    REG_THRESHOLD: r_thr     <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_item) begin
                r_have <= 1'b0;
            end
            if (i_cmd.do_start) begin
                r_running <= 1'b1;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (i < int'(n_used)) begin
                        r_total[i] <= '0;
                        r_last[i]  <= r_now;
                        r_first[i] <= r_now;
                        r_prev[i]  <= (i < 4) ? r_levels[i[1:0]] : 1'b0;
                    end
                end
            end
            if (i_cmd.do_stop) begin
                r_running <= 1'b0;
            end
            if (i_cmd.edge_step && changed) begin
                r_prev[i_ch] <= lvl;
                r_have       <= 1'b1;
                if (lvl) begin
                    r_last[i_ch] <= r_now;
                    if (gap_ok) begin
                        if (cur_total == r_thr) begin
                            r_first[i_ch] <= r_now;
                        end
                        if (cur_total != 16'hFFFF) begin
                            r_total[i_ch] <= cur_total + 16'd1;
                        end
                    end
                end
            end
            if (i_cmd.idle_step && timed_out && last_pos) begin
                r_total[i_ch] <= '0;
                r_last[i_ch]  <= r_now;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.req      = r_req;
    assign o_stat.running  = r_running;
    assign o_stat.n_zero   = (n_used == '0);
    assign o_stat.last_ch  = ((int'(i_ch) + 1) == int'(n_used));
    assign o_stat.out_free = out_free;

endmodule

`default_nettype wire

// ----- src/fppd_ctrl.sv -----
// Controller of the flow pulse pour detector: dispatches requests and sequences
// the edge pass and idle pass over the channels, then the status result.
// Depends on fppd_pkg.
`default_nettype none

module fppd_ctrl #(
    parameter int CHANNELS = fppd_pkg::CHANNELS_DEF,
    parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_stall,
    input  wire fppd_pkg::t_stat  i_stat,
    output      fppd_pkg::t_cmd   o_cmd,
    output      logic [CW-1:0]    o_ch
);
    import fppd_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_EDGE     = 3'd2;
    localparam logic [2:0] S_IDLE_CHK = 3'd3;
    localparam logic [2:0] S_STATUS   = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_ch;
    logic [CW-1:0] n_ch;
    t_cmd          cmd;

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_ch = '0;
                unique case (i_stat.req)
                    REQ_START: begin
                        cmd.do_start = 1'b1;
                        n_state      = S_IDLE;
                    end
                    REQ_STOP: begin
                        cmd.do_stop = 1'b1;
                        n_state     = S_IDLE;
                    end
                    REQ_SAMPLE: begin
                        n_state = (i_stat.running && !i_stat.n_zero) ? S_EDGE : S_STATUS;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EDGE: begin
                if (i_stat.out_free) begin
                    cmd.edge_step = 1'b1;
                    if (i_stat.last_ch) begin
                        n_ch    = '0;
                        n_state = S_IDLE_CHK;
                    end else begin
                        n_ch = r_ch + CW'(1);
                    end
                end
            end
            S_IDLE_CHK: begin
                if (i_stat.out_free) begin
                    cmd.idle_step = 1'b1;
                    if (i_stat.last_ch) begin
                        n_ch    = '0;
                        n_state = S_STATUS;
                    end else begin
                        n_ch = r_ch + CW'(1);
                    end
                end
            end
            S_STATUS: begin
                if (i_stat.out_free) begin
                    cmd.emit_status = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    assign o_cmd      = cmd;
    assign o_ch       = r_ch;
    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.edge_step || cmd.idle_step || cmd.emit_status) |-> i_stat.out_free)
        else $error("Channel step or status issued while the result register is busy.");

    a_pass_has_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE || r_state == S_IDLE_CHK) |-> !i_stat.n_zero)
        else $error("Channel pass entered with no active channels.");

    a_status_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_status |=> (r_state == S_IDLE && r_ch == '0))
        else $error("Controller did not return to idle after the status result.");

    a_edge_to_idle_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.edge_step && i_stat.last_ch) |=> (r_state == S_IDLE_CHK && r_ch == '0))
        else $error("Idle pass did not follow the last channel of the edge pass.");
`endif

endmodule

`default_nettype wire

// ----- src/flow_pulse_pour_detector.sv -----
// Top level of the flow pulse pour detector: joins the controller and the datapath.
// Depends on fppd_pkg, fppd_ctrl and fppd_datapath.
// A start or stop transaction goes through the dispatch state and then back to idle. A sample
// transaction goes through dispatch, an edge pass and an idle pass over N channels and the
// status state, where N is the number of active channels capped at CHANNELS while the block is
// running and zero while it is stopped. The passes and the status state wait while the output
// side stalls a result. The channel sequencer visits one channel per cycle in an edge pass and
// then in an idle pass, while the result register is free. Results wait in an output register,
// so the next transaction is accepted while the status result is still pending.
`default_nettype none

module flow_pulse_pour_detector #(
    parameter int CHANNELS = fppd_pkg::CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire fppd_pkg::t_in_item            i_in_data,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      fppd_pkg::t_out_item           o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fppd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fppd_pkg::PDATA_W-1:0]  pwdata,
    output      logic [fppd_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready
);
    import fppd_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_cmd          cmd;
    t_stat         stat;
    logic [CW-1:0] ch;

    assign pready = 1'b1;

    fppd_ctrl #(
        .CHANNELS (CHANNELS),
        .CW       (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_ch       (ch)
    );

    fppd_datapath #(
        .CHANNELS (CHANNELS),
        .CW       (CW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_cmd       (cmd),
        .i_ch        (ch),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire
